// ----- hdl/iss_pkg.sv -----
// shared constants, command and status types for the interleaved sector sequencer
package iss_pkg;

    // default geometry
    localparam int MAX_SECTORS_DEF   = 21;
    localparam int SKIPPED_TRACK_DEF = 18;

    // input function codes
    localparam logic [1:0] FUNC_SEEK    = 2'd0;
    localparam logic [1:0] FUNC_STEP    = 2'd1;
    localparam logic [1:0] FUNC_STEP_IN = 2'd2;

    // track start modes (any other code carries the sector)
    localparam logic [1:0] MODE_SKEW    = 2'd1;
    localparam logic [1:0] MODE_RESTART = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_ZONE0    = 3'd0;
    localparam logic [2:0] REG_ZONE1    = 3'd1;
    localparam logic [2:0] REG_ZONE2    = 3'd2;
    localparam logic [2:0] REG_ZONE3    = 3'd3;
    localparam logic [2:0] REG_MODE     = 3'd4;
    localparam logic [2:0] REG_FULL_SUB = 3'd5;

    // configuration reset values
    localparam logic [7:0] ZONE0_STEP_RST = 8'd4;
    localparam logic [7:0] ZONEX_STEP_RST = 8'd3;

    // speed zone boundaries and sector counts
    localparam logic [7:0] ZONE1_FIRST   = 8'd18;
    localparam logic [7:0] ZONE2_FIRST   = 8'd25;
    localparam logic [7:0] ZONE3_FIRST   = 8'd31;
    localparam logic [4:0] ZONE0_SECTORS = 5'd21;
    localparam logic [4:0] ZONE1_SECTORS = 5'd19;
    localparam logic [4:0] ZONE2_SECTORS = 5'd18;
    localparam logic [4:0] ZONE3_SECTORS = 5'd17;

    // skew amounts at track start
    localparam logic [7:0] SKEW_STEP  = 8'd2;
    localparam logic [7:0] SKEW_EXTRA = 8'd8;

    // controller to datapath commands
    typedef struct packed {
        logic seek_load;   // take track, sector and target from the input beat
        logic enter;       // enter current track: zone, count, clear map
        logic mark;        // mark current sector used, count down
        logic adv_step;    // advance by the zone step
        logic adv_one;     // advance by one sector
        logic track_inc;   // move to the next track, passing the skipped one
        logic start_fix;   // apply the track start mode
        logic load_out;    // load the result register
        logic changed;     // track changed flag for the result
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic left_nz;
        logic left_gt_target;
        logic cur_used;
        logic skew;
    } t_stat;

endpackage

// ----- hdl/iss_dp.sv -----
// datapath: configuration, track and sector state, used map and result register
module iss_dp #(
    parameter int MAX_SECTORS   = iss_pkg::MAX_SECTORS_DEF,
    parameter int SKIPPED_TRACK = iss_pkg::SKIPPED_TRACK_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic [2:0]          i_cfg_index,
    input  logic [7:0]          i_cfg_data,
    input  logic [7:0]          i_start_track,
    input  logic [7:0]          i_start_sector,
    input  logic [4:0]          i_target_left,
    input  iss_pkg::t_cmd       i_cmd,
    output iss_pkg::t_stat      o_stat,
    output logic [7:0]          o_track,
    output logic [7:0]          o_sector,
    output logic [4:0]          o_sectors_left,
    output logic                o_track_changed
);

    localparam int         IDXW      = $clog2(MAX_SECTORS);
    localparam logic [7:0] MAP_LIMIT = 8'(MAX_SECTORS);
    localparam logic [7:0] SKIP_TRK  = 8'(SKIPPED_TRACK);
    localparam logic [7:0] AFTER_SKP = 8'(SKIPPED_TRACK + 1);

    // configuration
    logic [7:0] r_zone0, r_zone1, r_zone2, r_zone3;
    logic [1:0] r_mode;
    logic       r_full_sub;

    // sequencer state
    logic [7:0]             r_cur_track, n_cur_track;
    logic [7:0]             r_cur_sector, n_cur_sector;
    logic [4:0]             r_left, n_left;
    logic [4:0]             r_zone_sectors, n_zone_sectors;
    logic [7:0]             r_zone_step, n_zone_step;
    logic [MAX_SECTORS-1:0] r_used_map, n_used_map;
    logic [4:0]             r_target;

    // result register
    logic [7:0] r_out_track, r_out_sector;
    logic [4:0] r_out_left;
    logic       r_out_changed;

    logic       in_map;
    logic [7:0] zs8;
    logic [7:0] adv_d, adv_sum, adv_wrap, adv_res;
    logic       corr;
    logic [4:0] ent_sectors;
    logic [7:0] ent_step;
    logic [7:0] inc_trk;
    logic       inc_hit;
    logic [7:0] fix_a, fix_b, fix_c;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone0    <= iss_pkg::ZONE0_STEP_RST;
            r_zone1    <= iss_pkg::ZONEX_STEP_RST;
            r_zone2    <= iss_pkg::ZONEX_STEP_RST;
            r_zone3    <= iss_pkg::ZONEX_STEP_RST;
            r_mode     <= 2'd0;
            r_full_sub <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                iss_pkg::REG_ZONE0:    r_zone0    <= i_cfg_data;
                iss_pkg::REG_ZONE1:    r_zone1    <= i_cfg_data;
                iss_pkg::REG_ZONE2:    r_zone2    <= i_cfg_data;
                iss_pkg::REG_ZONE3:    r_zone3    <= i_cfg_data;
                iss_pkg::REG_MODE:     r_mode     <= i_cfg_data[1:0];
                iss_pkg::REG_FULL_SUB: r_full_sub <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // used map lookup, sectors past the map read as unused
    assign in_map = r_cur_sector < MAP_LIMIT;
    assign zs8    = {3'b000, r_zone_sectors};

    // sector advance with wrap and one-sector correction
    always_comb begin
        adv_d    = i_cmd.adv_one ? 8'd1 : r_zone_step;
        adv_sum  = r_cur_sector + adv_d;
        adv_wrap = adv_sum - zs8;
        corr     = r_full_sub || (r_cur_track < iss_pkg::ZONE1_FIRST);
        if (adv_sum >= zs8) begin
            adv_res = (corr && (adv_wrap != 8'd0)) ? adv_wrap - 8'd1 : adv_wrap;
        end else begin
            adv_res = adv_sum;
        end
    end

    // zone of the current track
    always_comb begin
        if (r_cur_track < iss_pkg::ZONE1_FIRST) begin
            ent_sectors = iss_pkg::ZONE0_SECTORS;
            ent_step    = r_zone0;
        end else if (r_cur_track < iss_pkg::ZONE2_FIRST) begin
            ent_sectors = iss_pkg::ZONE1_SECTORS;
            ent_step    = r_zone1;
        end else if (r_cur_track < iss_pkg::ZONE3_FIRST) begin
            ent_sectors = iss_pkg::ZONE2_SECTORS;
            ent_step    = r_zone2;
        end else begin
            ent_sectors = iss_pkg::ZONE3_SECTORS;
            ent_step    = r_zone3;
        end
    end

    // next track, passing over the skipped one
    assign inc_trk = r_cur_track + 8'd1;
    assign inc_hit = inc_trk == SKIP_TRK;

    // skew at track start, folded back into the zone when negative
    always_comb begin
        fix_a = r_cur_sector - iss_pkg::SKEW_STEP;
        fix_b = (r_cur_track == AFTER_SKP) ? fix_a - iss_pkg::SKEW_EXTRA : fix_a;
        fix_c = fix_b[7] ? fix_b + zs8 : fix_b;
    end

    // next state selection
    always_comb begin
        n_cur_track    = r_cur_track;
        n_cur_sector   = r_cur_sector;
        n_left         = r_left;
        n_zone_sectors = r_zone_sectors;
        n_zone_step    = r_zone_step;
        n_used_map     = r_used_map;
        if (i_cmd.seek_load) begin
            n_cur_track  = i_start_track;
            n_cur_sector = i_start_sector;
        end else if (i_cmd.track_inc) begin
            n_cur_track  = inc_hit ? inc_trk + 8'd1 : inc_trk;
            n_cur_sector = inc_hit ? r_cur_sector + iss_pkg::SKEW_STEP : r_cur_sector;
        end else if (i_cmd.start_fix) begin
            case (r_mode)
                iss_pkg::MODE_SKEW:    n_cur_sector = fix_c;
                iss_pkg::MODE_RESTART: n_cur_sector = 8'd0;
                default:               n_cur_sector = r_cur_sector;
            endcase
        end else if (i_cmd.adv_step || i_cmd.adv_one) begin
            n_cur_sector = adv_res;
        end
        if (i_cmd.enter) begin
            n_zone_sectors = ent_sectors;
            n_zone_step    = ent_step;
            n_left         = ent_sectors;
            n_used_map     = '0;
        end else if (i_cmd.mark) begin
            if (r_left != 5'd0) begin
                n_left = r_left - 5'd1;
            end
            if (in_map) begin
                n_used_map[r_cur_sector[IDXW-1:0]] = 1'b1;
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_track    <= 8'd0;
            r_cur_sector   <= 8'd0;
            r_left         <= 5'd0;
            r_zone_sectors <= 5'd0;
            r_zone_step    <= 8'd0;
            r_used_map     <= '0;
        end else begin
            r_cur_track    <= n_cur_track;
            r_cur_sector   <= n_cur_sector;
            r_left         <= n_left;
            r_zone_sectors <= n_zone_sectors;
            r_zone_step    <= n_zone_step;
            r_used_map     <= n_used_map;
        end
    end

    // seek target and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.seek_load) begin
            r_target <= i_target_left;
        end
        if (i_cmd.load_out) begin
            r_out_track   <= r_cur_track;
            r_out_sector  <= r_cur_sector;
            r_out_left    <= r_left;
            r_out_changed <= i_cmd.changed;
        end
    end

    // status to the controller
    assign o_stat.left_nz        = r_left != 5'd0;
    assign o_stat.left_gt_target = r_left > r_target;
    assign o_stat.cur_used       = in_map && r_used_map[r_cur_sector[IDXW-1:0]];
    assign o_stat.skew           = r_mode == iss_pkg::MODE_SKEW;

    assign o_track         = r_out_track;
    assign o_sector        = r_out_sector;
    assign o_sectors_left  = r_out_left;
    assign o_track_changed = r_out_changed;

endmodule

// ----- hdl/iss_ctrl.sv -----
// controller: step sequencing state machine and result handshake
module iss_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [1:0]     i_func,
    output logic           o_valid,
    input  logic           i_ready,
    input  iss_pkg::t_stat i_stat,
    output iss_pkg::t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_ENTER    = 4'd1;
    localparam logic [3:0] S_SEEK_CHK = 4'd2;
    localparam logic [3:0] S_MARK     = 4'd3;
    localparam logic [3:0] S_ADV      = 4'd4;
    localparam logic [3:0] S_SKIP     = 4'd5;
    localparam logic [3:0] S_TINC     = 4'd6;
    localparam logic [3:0] S_TENTER   = 4'd7;
    localparam logic [3:0] S_TFIX     = 4'd8;
    localparam logic [3:0] S_DONE     = 4'd9;

    logic [3:0] r_state, n_state;
    logic [1:0] r_func, n_func;
    logic       r_changed, n_changed;
    logic [8:0] r_guard, n_guard;
    logic       r_out_valid, n_out_valid;
    logic       in_beat, out_free;

    assign o_ready  = r_state == S_IDLE;
    assign in_beat  = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;

    // sequencing
    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_changed   = r_changed;
        n_guard     = r_guard;
        n_out_valid = r_out_valid && !i_ready;
        o_cmd       = '0;
        o_cmd.changed = r_changed;
        case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_func    = i_func;
                    n_changed = 1'b0;
                    case (i_func)
                        iss_pkg::FUNC_SEEK: begin
                            o_cmd.seek_load = 1'b1;
                            n_changed       = 1'b1;
                            n_state         = S_ENTER;
                        end
                        iss_pkg::FUNC_STEP,
                        iss_pkg::FUNC_STEP_IN: n_state = S_MARK;
                        default:               n_state = S_DONE;
                    endcase
                end
            end
            S_ENTER: begin
                o_cmd.enter = 1'b1;
                n_state     = S_SEEK_CHK;
            end
            // seek iterates while more than the target remain
            S_SEEK_CHK: begin
                n_state = i_stat.left_gt_target ? S_MARK : S_DONE;
            end
            S_MARK: begin
                o_cmd.mark = 1'b1;
                n_state    = S_ADV;
            end
            S_ADV: begin
                o_cmd.adv_step = i_stat.left_nz || !i_stat.skew;
                n_guard        = 9'd0;
                n_state        = S_SKIP;
            end
            // skip used sectors one per cycle, bounded at 256 steps
            S_SKIP: begin
                if (i_stat.left_nz && i_stat.cur_used && !r_guard[8]) begin
                    o_cmd.adv_one = 1'b1;
                    n_guard       = r_guard + 9'd1;
                end else begin
                    case (r_func)
                        iss_pkg::FUNC_SEEK: n_state = S_SEEK_CHK;
                        iss_pkg::FUNC_STEP: n_state = i_stat.left_nz ? S_DONE : S_TINC;
                        default:            n_state = S_DONE;
                    endcase
                end
            end
            S_TINC: begin
                o_cmd.track_inc = 1'b1;
                n_changed       = 1'b1;
                n_state         = S_TENTER;
            end
            S_TENTER: begin
                o_cmd.enter = 1'b1;
                n_state     = S_TFIX;
            end
            S_TFIX: begin
                o_cmd.start_fix = 1'b1;
                n_state         = S_DONE;
            end
            // hand the result to the output register
            S_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_func      <= 2'd0;
            r_changed   <= 1'b0;
            r_guard     <= 9'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_func      <= n_func;
            r_changed   <= n_changed;
            r_guard     <= n_guard;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;

endmodule

// ----- hdl/interleaved_sector_sequencer_unit.sv -----
// top level of the interleaved sector sequencer
//
// Input channel i_valid/o_ready carries one step request per beat: a function
// code (seek, advance with track change, advance within track) and, for seek,
// the entry track, sector and the number of sectors that should remain.
// Output channel o_valid/i_ready returns one beat per request with the track,
// sector, sectors left and a track changed flag.
// The configuration channel i_cfg_valid/o_cfg_ready is always ready and writes
// the zone interleaves, track start mode and full subsector flag; write it only
// while no request is in flight.
// A request runs through the controller states: an unused function code goes
// straight to the result; an advance marks the current sector, steps by the
// zone interleave and skips used sectors one per cycle, and at a track end
// moves to the next track, enters it and applies the track start mode; a seek
// enters its track and runs the mark, step, skip sequence for each sector
// consumed while more than the target remain.
// One request is worked at a time; the next is taken as soon as the result
// sits in the output register, even while the receiver stalls it.
// Reset clears the track state and used map and restores default configuration.
module interleaved_sector_sequencer_unit #(
    parameter int MAX_SECTORS   = iss_pkg::MAX_SECTORS_DEF,
    parameter int SKIPPED_TRACK = iss_pkg::SKIPPED_TRACK_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_func,
    input  logic [7:0] i_start_track,
    input  logic [7:0] i_start_sector,
    input  logic [4:0] i_target_left,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_track,
    output logic [7:0] o_sector,
    output logic [4:0] o_sectors_left,
    output logic       o_track_changed,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    iss_pkg::t_cmd  cmd;
    iss_pkg::t_stat stat;

    // configuration writes are always accepted and registered directly
    assign o_cfg_ready = 1'b1;

    // sequencing control
    iss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_func  (i_func),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // track and sector datapath
    iss_dp #(
        .MAX_SECTORS   (MAX_SECTORS),
        .SKIPPED_TRACK (SKIPPED_TRACK)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_start_track   (i_start_track),
        .i_start_sector  (i_start_sector),
        .i_target_left   (i_target_left),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_track         (o_track),
        .o_sector        (o_sector),
        .o_sectors_left  (o_sectors_left),
        .o_track_changed (o_track_changed)
    );

endmodule

// ----- hdl/iss_checker.sv -----
// port-level checker for the interleaved sector sequencer, with its bind
module iss_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_track,
    input logic [7:0] o_sector,
    input logic [4:0] o_sectors_left
);

    // a stalled result beat stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result beat dropped while stalled");

    // a stalled result beat keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_track) && $stable(o_sector)
                                && $stable(o_sectors_left))
        else $error("result payload changed while stalled");

    // the sector count never exceeds the largest zone
    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_sectors_left <= iss_pkg::ZONE0_SECTORS)
        else $error("sectors left beyond zone size");

    // a request beat never yields a result in the next cycle
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && !o_valid |=> !o_valid)
        else $error("result appeared without sequencing");

    // nothing is offered straight after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("block not idle after reset");

endmodule

bind interleaved_sector_sequencer_unit iss_checker u_iss_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_track        (o_track),
    .o_sector       (o_sector),
    .o_sectors_left (o_sectors_left)
);
